// ===== src/ccs_pkg.sv =====
// Shared package of the chase camera smoother: widths, register codes and the sine table.
// Used by every module in src; depends on nothing.
package ccs_pkg;

   localparam int DataW = 32;
   localparam int RegW = 23;
   localparam int AngW = 16;
   localparam int SineEntries = 256;
   localparam int SineIdxW = $clog2(SineEntries);

   localparam logic [1:0] REG_DISTANCE = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_LOOK = 2'd2;

   localparam logic [RegW-1:0] DistanceReset = 23'd655360;
   localparam logic [RegW-1:0] HeightReset = 23'd327680;
   localparam logic [RegW-1:0] LookReset = 23'd327680;
   localparam logic [DataW-1:0] CamYReset = 32'd458752;
   localparam logic [DataW-1:0] CamZReset = 32'd983040;

   localparam logic [16:0] SpeedFull = 17'd65536;
   localparam logic [12:0] SmoothBase = 13'd1966;
   localparam logic [12:0] SmoothSpan = 13'd4588;

   // Serial multiplier command: magnitude a times magnitude b, shifted right by 16 with rounding.
   typedef struct packed {
      logic start;
      logic [DataW:0] a;
      logic [16:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic done;
      logic [DataW+1:0] prod;
   } mul_rsp_type;

   // Restoring division, used only while the sine table is built.
   function automatic longint unsigned series_quot(input longint unsigned n,
                                                   input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave sine entry, built from the Taylor series at elaboration.
   function automatic logic [15:0] sine_entry(input int k);
      longint unsigned x;
      longint unsigned t;
      longint sum;
      longint e;
      x = (longint'(k) * 64'd1686629713) >> SineIdxW;
      t = x;
      sum = longint'(x);
      for (int i = 1; i <= 6; i++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = series_quot(t, 64'((2 * i) * (2 * i + 1)));
         if ((i & 1) == 1) sum = sum - longint'(t);
         else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      e = longint'((unsigned'(sum) * 64'd65535 + (64'd1 << 29)) >> 30);
      if (e > 65535) e = 65535;
      return e[15:0];
   endfunction

   typedef logic [15:0] sine_rom_type [SineEntries];

   function automatic sine_rom_type build_sine();
      sine_rom_type r;
      for (int k = 0; k < SineEntries; k++) r[k] = sine_entry(k);
      return r;
   endfunction

   localparam sine_rom_type SineRom = build_sine();

endpackage

// ===== src/ccs_mul.sv =====
// Bit-serial shift-add multiplier of the chase camera smoother: one multiplier bit per cycle.
// Depends on ccs_pkg.
module ccs_mul (
   input  logic clock,
   input  logic reset,
   input  ccs_pkg::mul_cmd_type cmd,
   output ccs_pkg::mul_rsp_type rsp
);

   localparam int AccW = ccs_pkg::DataW + 18;

   logic [AccW-1:0] acc_ff, acc_in;
   logic [ccs_pkg::DataW:0] a_ff, a_in;
   logic [16:0] b_ff, b_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [AccW-1:0] rounded;

   // Partial products enter at the top; the accumulator shifts right one bit a cycle.
   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in = '0;
         a_in = cmd.a;
         b_in = cmd.b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff + (b_ff[0] ? {a_ff, 17'd0} : '0)) >> 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // After 17 steps acc holds a*b; add half and drop 16 fraction bits.
   assign rounded = acc_ff + AccW'(32768);
   assign rsp.done = done_ff;
   assign rsp.prod = rounded[16 +: ccs_pkg::DataW + 2];

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   property p_done_ends_busy;
      @(posedge clock) disable iff (reset) rsp.done |-> !busy_ff;
   endproperty
   assert property (p_done_ends_busy) else $error("multiplier done while busy");

   property p_start_busy;
      @(posedge clock) disable iff (reset) cmd.start |=> busy_ff;
   endproperty
   assert property (p_start_busy) else $error("multiplier did not start");

   property p_done_single;
      @(posedge clock) disable iff (reset) rsp.done |=> !rsp.done;
   endproperty
   assert property (p_done_single) else $error("multiplier done twice");

endmodule

// ===== src/chase_camera_smoother_top.sv =====
// Top level of the chase camera smoother: handshakes, registers, sequencer and state.
// Depends on ccs_pkg and ccs_mul.
//
//  channel  direction  tdata fields (low bit first)                 tuser
//  req      in         pos_x, pos_y, pos_z, heading_angle, speed    -
//  rsp      out        cam_x, cam_y, cam_z, aim_x, aim_y, aim_z     -
//  csr      in         index (2 bits), data (23 bits)               -
//
// One shared bit-serial multiplier forms every product: eleven products,
// the speed factor, four offsets and six steps, run in turn by the sequencer;
// rsp_tvalid is registered from the S_OUT state.
// The speed divide by five makes an alignment shift and then forms one quotient
// bit per cycle; a saturated speed skips it.
// Reset is synchronous and active high and restores registers and points.
// The block takes one item at a time; a result waits in the output register
// while rsp_tready is low, and the next item is taken once it is transferred.
module chase_camera_smoother_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // pos_x, pos_y, pos_z, heading_angle, speed
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,  // cam_x, cam_y, cam_z, aim_x, aim_y, aim_z
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [22:0]  csr_data
);

   localparam int W = ccs_pkg::DataW;

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV = 4'd1;
   localparam logic [3:0] S_FACT = 4'd2;
   localparam logic [3:0] S_TRIG = 4'd3;
   localparam logic [3:0] S_OFFS = 4'd4;
   localparam logic [3:0] S_GOAL = 4'd5;
   localparam logic [3:0] S_STEP = 4'd6;
   localparam logic [3:0] S_WAIT = 4'd7;
   localparam logic [3:0] S_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [ccs_pkg::RegW-1:0] dist_ff, height_ff, look_ff;
   logic signed [W-1:0] cam_ff [3];
   logic signed [W-1:0] aim_ff [3];
   logic signed [W-1:0] px_ff, py_ff, pz_ff;
   logic [15:0] ang_ff;
   logic [W:0] spd_ff, spd_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic [2:0] rem_ff, rem_in;
   logic [12:0] fac_ff;
   logic [16:0] sin_ff, cos_ff;
   logic sin_neg_ff, cos_neg_ff;
   // Offsets: distance*sin, distance*cos, look*sin, look*cos.
   logic [W+1:0] off_ff [4];
   logic signed [W-1:0] goal_ff [6];
   logic [2:0] idx_ff, idx_in;
   logic mul_wait_ff;
   logic [191:0] out_ff;
   logic out_valid_ff;

   ccs_pkg::mul_cmd_type mcmd;
   ccs_pkg::mul_rsp_type mrsp;

   ccs_mul u_mul (.clock(clock), .reset(reset), .cmd(mcmd), .rsp(mrsp));

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;

   // Sine magnitude lookup for a binary angle.
   function automatic logic [16:0] trig_mag(input logic [15:0] a);
      logic [14:0] o;
      o = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
      if (o[14]) return 17'd65535;
      return {1'b0, ccs_pkg::SineRom[o[13 -: ccs_pkg::SineIdxW]]};
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] v);
      if (v > (W+3)'(signed'(33'sh7FFFFFFF))) return 32'sh7FFFFFFF;
      if (v < -(W+3)'(signed'(34'sh080000000))) return 32'sh80000000;
      return v[W-1:0];
   endfunction

   logic [15:0] cang;
   logic signed [W:0] diff;
   logic [W:0] dmag;
   logic [3:0] trial;
   logic signed [W+2:0] g0, g2, g3, g5;
   logic signed [W-1:0] old_pt, goal_pt, new_pt;
   logic [W+1:0] step;

   assign cang = ang_ff + 16'd16384;
   assign trial = {rem_ff, spd_ff[W]};

   always_comb begin
      old_pt = (idx_ff < 3'd3) ? cam_ff[idx_ff[1:0]] : aim_ff[2'(idx_ff - 3'd3)];
      goal_pt = goal_ff[idx_ff];
      diff = (W+1)'(goal_pt) - (W+1)'(old_pt);
      dmag = diff[W] ? -diff : diff;
      step = mrsp.prod;
      new_pt = diff[W] ? W'(old_pt - step[W-1:0]) : W'(old_pt + step[W-1:0]);
   end

   always_comb begin
      g0 = (W+3)'(px_ff) + (sin_neg_ff ? -(W+3)'(signed'({1'b0, off_ff[0]}))
                                       : (W+3)'(signed'({1'b0, off_ff[0]})));
      g2 = (W+3)'(pz_ff) - (cos_neg_ff ? -(W+3)'(signed'({1'b0, off_ff[1]}))
                                       : (W+3)'(signed'({1'b0, off_ff[1]})));
      g3 = (W+3)'(px_ff) - (sin_neg_ff ? -(W+3)'(signed'({1'b0, off_ff[2]}))
                                       : (W+3)'(signed'({1'b0, off_ff[2]})));
      g5 = (W+3)'(pz_ff) + (cos_neg_ff ? -(W+3)'(signed'({1'b0, off_ff[3]}))
                                       : (W+3)'(signed'({1'b0, off_ff[3]})));
   end

   // Sequencer: divide, speed factor with trig, four offsets, goals, six steps, output.
   always_comb begin
      state_in = state_ff;
      spd_in = spd_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      rem_in = rem_ff;
      idx_in = idx_ff;
      mcmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               // Magnitude of the sign-extended speed; the most negative value gives 2^31.
               spd_in = req_tdata[143] ? (W+1)'(-{1'b1, req_tdata[143:112]})
                                       : (W+1)'({1'b0, req_tdata[143:112]});
               quo_in = '0;
               rem_in = '0;
               dcnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring divide by five over the low 19 bits after the saturation test.
            if (spd_ff >= (W+1)'(327680) && dcnt_ff == 5'd0) begin
               quo_in = ccs_pkg::SpeedFull;
               state_in = S_FACT;
            end else begin
               if (dcnt_ff == 5'd0) spd_in = spd_ff << (W - 18);
               else begin
                  spd_in = spd_ff << 1;
                  rem_in = (trial >= 4'd5) ? 3'(trial - 4'd5) : trial[2:0];
                  quo_in = {quo_ff[15:0], trial >= 4'd5};
               end
               dcnt_in = dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd19) state_in = S_FACT;
            end
         end
         S_FACT: begin
            if (!mul_wait_ff) begin
               mcmd.start = 1'b1;
               mcmd.a = (W+1)'(ccs_pkg::SmoothSpan);
               mcmd.b = quo_ff;
            end else if (mrsp.done) begin
               idx_in = '0;
               state_in = S_OFFS;
            end
         end
         S_TRIG: state_in = S_OFFS;
         S_OFFS: begin
            if (!mul_wait_ff) begin
               mcmd.start = 1'b1;
               mcmd.a = (W+1)'(idx_ff[1] ? look_ff : dist_ff);
               mcmd.b = idx_ff[0] ? cos_ff : sin_ff;
            end else if (mrsp.done) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd3) state_in = S_GOAL;
            end
         end
         S_GOAL: begin
            idx_in = '0;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (!mul_wait_ff) begin
               mcmd.start = 1'b1;
               mcmd.a = dmag;
               mcmd.b = {4'd0, fac_ff};
            end else if (mrsp.done) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd5) state_in = S_OUT;
            end
         end
         S_WAIT: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mul_wait_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         dist_ff <= ccs_pkg::DistanceReset;
         height_ff <= ccs_pkg::HeightReset;
         look_ff <= ccs_pkg::LookReset;
         cam_ff[0] <= '0;
         cam_ff[1] <= ccs_pkg::CamYReset;
         cam_ff[2] <= ccs_pkg::CamZReset;
         for (int i = 0; i < 3; i++) aim_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (mcmd.start) mul_wait_ff <= 1'b1;
         else if (mrsp.done) mul_wait_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ccs_pkg::REG_DISTANCE: dist_ff <= csr_data;
               ccs_pkg::REG_HEIGHT: height_ff <= csr_data;
               ccs_pkg::REG_LOOK: look_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_STEP && mul_wait_ff && mrsp.done) begin
            if (idx_ff < 3'd3) cam_ff[idx_ff[1:0]] <= new_pt;
            else aim_ff[2'(idx_ff - 3'd3)] <= new_pt;
         end
         if (state_ff == S_OUT) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      spd_ff <= spd_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      if (state_ff == S_IDLE && req_tvalid && req_tready) begin
         px_ff <= req_tdata[31:0];
         py_ff <= req_tdata[63:32];
         pz_ff <= req_tdata[95:64];
         ang_ff <= req_tdata[111:96];
      end
      if (state_ff == S_FACT) begin
         sin_ff <= trig_mag(ang_ff);
         sin_neg_ff <= ang_ff[15];
         cos_ff <= trig_mag(cang);
         cos_neg_ff <= cang[15];
      end
      if (state_ff == S_FACT && mul_wait_ff && mrsp.done)
         fac_ff <= ccs_pkg::SmoothBase + 13'(mrsp.prod);
      if (state_ff == S_OFFS && mul_wait_ff && mrsp.done) off_ff[idx_ff[1:0]] <= mrsp.prod;
      if (state_ff == S_GOAL) begin
         goal_ff[0] <= sat(g0);
         goal_ff[1] <= sat((W+3)'(py_ff) + (W+3)'(signed'({1'b0, height_ff})));
         goal_ff[2] <= sat(g2);
         goal_ff[3] <= sat(g3);
         goal_ff[4] <= py_ff;
         goal_ff[5] <= sat(g5);
      end
      if (state_ff == S_OUT)
         out_ff <= {aim_ff[2], aim_ff[1], aim_ff[0], cam_ff[2], cam_ff[1], cam_ff[0]};
   end

   property p_no_take_while_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_tready;
   endproperty
   assert property (p_no_take_while_busy) else $error("input taken while busy");

   property p_out_after_seq;
      @(posedge clock) disable iff (reset) $rose(out_valid_ff) |-> $past(state_ff) == S_OUT;
   endproperty
   assert property (p_out_after_seq) else $error("result without sequence");

   property p_out_held;
      @(posedge clock) disable iff (reset) (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata);
   endproperty
   assert property (p_out_held) else $error("pending result changed");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the chase camera smoother: directed table, then random frames.
// Depends on ccs_pkg and chase_camera_smoother_top; predicts every response in SystemVerilog.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomFrames = 1300;
   localparam longint CycleLimit = 64'd3_000_000;
   localparam int SettleCycles = 400;
   // Register index that names no register; a write to it changes nothing.
   localparam logic [1:0] RegUnused = 2'd3;

   typedef struct packed {
      logic signed [31:0] speed;
      logic [15:0]        heading;
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } frame_type;

   typedef struct packed {
      logic signed [31:0] az, ay, ax, cz, cy, cx;
   } view_type;

   typedef struct {
      frame_type fr;
      bit        has_view;
      view_type  view;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = ccs_pkg::REG_DISTANCE;
   logic [22:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   chase_camera_smoother_top dut (.*);

   // Predictor state: registers, the two smoothed points and its own sine table.
   logic [22:0] dist_reg, height_reg, look_reg;
   longint cam_pt [3];
   longint aim_pt [3];
   logic [15:0] quarter_sine [ccs_pkg::SineEntries];
   view_type view_queue [$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   longint cycles = 0;

   function automatic void fill_sine();
      longint unsigned x, t;
      longint sum, e;
      for (int k = 0; k < ccs_pkg::SineEntries; k++) begin
         x = (longint'(k) * 64'd1686629713) / ccs_pkg::SineEntries;
         t = x;
         sum = longint'(x);
         for (int i = 1; i <= 6; i++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / ((2 * i) * (2 * i + 1));
            sum = (i % 2 == 1) ? sum - longint'(t) : sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         e = longint'((unsigned'(sum) * 64'd65535 + (64'd1 << 29)) >> 30);
         if (e > 65535) e = 65535;
         quarter_sine[k] = e[15:0];
      end
   endfunction

   function automatic longint quarter_mag(int unsigned o);
      if (o >= 16384) return 65535;
      return longint'(quarter_sine[(o * ccs_pkg::SineEntries) >> 14]);
   endfunction

   function automatic longint signed_sine(int unsigned a);
      int unsigned q, o;
      longint m;
      q = (a >> 14) & 3;
      o = a & 16383;
      m = q[0] ? quarter_mag(16384 - o) : quarter_mag(o);
      return q[1] ? -m : m;
   endfunction

   function automatic longint scaled(logic [22:0] r, longint trig);
      longint m, p;
      m = trig < 0 ? -trig : trig;
      p = (longint'(r) * m + 32768) >>> 16;
      return trig < 0 ? -p : p;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint glide(longint old, longint goal, longint f);
      longint d, m, s;
      d = goal - old;
      m = d < 0 ? -d : d;
      s = (m * f + 32768) >>> 16;
      return d < 0 ? old - s : old + s;
   endfunction

   // Advances the smoothed points by one frame and returns the new view.
   function automatic view_type advance_view(frame_type fr);
      longint px, py, pz, sp, mag, s, c, vf, f;
      longint cg [3];
      longint ag [3];
      view_type v;
      px = fr.px;
      py = fr.py;
      pz = fr.pz;
      sp = fr.speed;
      mag = sp < 0 ? -sp : sp;
      s = signed_sine(fr.heading);
      c = signed_sine((int'(fr.heading) + 16384) & 16'hFFFF);
      cg[0] = clamp32(px + scaled(dist_reg, s));
      cg[1] = clamp32(py + longint'(height_reg));
      cg[2] = clamp32(pz - scaled(dist_reg, c));
      ag[0] = clamp32(px - scaled(look_reg, s));
      ag[1] = py;
      ag[2] = clamp32(pz + scaled(look_reg, c));
      vf = mag >= 327680 ? 65536 : mag / 5;
      f = 1966 + ((4588 * vf + 32768) >>> 16);
      for (int i = 0; i < 3; i++) begin
         cam_pt[i] = glide(cam_pt[i], cg[i], f);
         aim_pt[i] = glide(aim_pt[i], ag[i], f);
      end
      v.cx = 32'(cam_pt[0]); v.cy = 32'(cam_pt[1]); v.cz = 32'(cam_pt[2]);
      v.ax = 32'(aim_pt[0]); v.ay = 32'(aim_pt[1]); v.az = 32'(aim_pt[2]);
      return v;
   endfunction

   // Response side: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   // Every response transfer is compared with the oldest expected view.
   always @(posedge clock) begin
      view_type got;
      view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (view_queue.size() == 0) begin
            $error("response with no view expected");
            errors++;
         end else begin
            want = view_queue.pop_front();
            if (got.cx !== want.cx) begin
               $error("cam_x exp %0d got %0d", want.cx, got.cx);
               errors++;
            end
            if (got.cy !== want.cy) begin
               $error("cam_y exp %0d got %0d", want.cy, got.cy);
               errors++;
            end
            if (got.cz !== want.cz) begin
               $error("cam_z exp %0d got %0d", want.cz, got.cz);
               errors++;
            end
            if (got.ax !== want.ax) begin
               $error("aim_x exp %0d got %0d", want.ax, got.ax);
               errors++;
            end
            if (got.ay !== want.ay) begin
               $error("aim_y exp %0d got %0d", want.ay, got.ay);
               errors++;
            end
            if (got.az !== want.az) begin
               $error("aim_z exp %0d got %0d", want.az, got.az);
               errors++;
            end
         end
      end
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sends one frame after a random gap; a typed view overrides the predictor's.
   task automatic send_frame(frame_type fr, bit has_view, view_type typed);
      view_type v;
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_tdata <= fr;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      v = advance_view(fr);
      view_queue.push_back(has_view ? typed : v);
      // Valid drops before the next frame, which then starts in a new time step.
      @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [22:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ccs_pkg::REG_DISTANCE: dist_reg = val;
         ccs_pkg::REG_HEIGHT: height_reg = val;
         ccs_pkg::REG_LOOK: look_reg = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Waits until every expected view has arrived, then lets the block settle.
   task automatic drain();
      while (view_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic frame_type random_frame();
      frame_type fr;
      fr.px = $urandom;
      fr.py = $urandom;
      fr.pz = $urandom;
      fr.heading = 16'($urandom);
      fr.speed = $urandom;
      // Mostly gentle motion near the origin so the smoothing stays visible.
      if ($urandom_range(3) != 0) begin
         fr.px = $signed($urandom_range(2000000)) - 1000000;
         fr.py = $signed($urandom_range(2000000)) - 1000000;
         fr.pz = $signed($urandom_range(2000000)) - 1000000;
         fr.speed = $signed($urandom_range(800000)) - 400000;
      end
      if ($urandom_range(15) == 0) fr.heading = 16'(32'h4000 * $urandom_range(3));
      return fr;
   endfunction

   function automatic frame_type mk(int x, int y, int z, int h, int sp);
      frame_type fr;
      fr.px = x; fr.py = y; fr.pz = z; fr.heading = 16'(h); fr.speed = sp;
      return fr;
   endfunction

   initial begin
      row_type rows [$];
      row_type r;
      view_type first_view;
      int phase_idle [4] = '{0, 81, 0, 32};
      int phase_stall [4] = '{0, 0, 81, 32};
      logic [22:0] setting [4][3] = '{
         '{23'd655360, 23'd327680, 23'd327680},
         '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF},
         '{23'd0, 23'd0, 23'd0},
         '{23'd131072, 23'h555555, 23'h2AAAAA}};

      dist_reg = ccs_pkg::DistanceReset;
      height_reg = ccs_pkg::HeightReset;
      look_reg = ccs_pkg::LookReset;
      cam_pt = '{0, 458752, 983040};
      aim_pt = '{0, 0, 0};
      fill_sine();

      // First frame from reset: object at rest at the origin heading zero.
      // Camera goal (0, 327680, -655350), aim goal (0, 0, 327675), factor 1966.
      first_view.cx = 0;
      first_view.cy = 32'(458752 - ((64'd131072 * 1966 + 32768) >> 16));
      first_view.cz = 32'(983040 - ((64'd1638390 * 1966 + 32768) >> 16));
      first_view.ax = 0;
      first_view.ay = 0;
      first_view.az = 32'((64'd327675 * 1966 + 32768) >> 16);

      rows.push_back('{mk(0, 0, 0, 0, 0), 1'b1, first_view});
      rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 32'h7FFFFFFF),
                      0, '0});
      rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 32'h80000000),
                      0, '0});
      rows.push_back('{mk(32'h7FFFFFFF, 0, 32'h80000000, 16'h4000, 327680), 0, '0});
      rows.push_back('{mk(32'h80000000, 0, 32'h7FFFFFFF, 16'hC000, -327679), 0, '0});
      rows.push_back('{mk(0, 0, 0, 16'h8000, 327679), 0, '0});
      rows.push_back('{mk(65536, -65536, 131072, 16'h2000, -1), 0, '0});
      rows.push_back('{mk(0, 0, 0, 16'h3FFF, 5), 0, '0});
      rows.push_back('{mk(0, 0, 0, 16'h4001, 4), 0, '0});
      rows.push_back('{mk(0, 0, 0, 16'hBFFF, 32'hAAAAAAAA), 0, '0});
      rows.push_back('{mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'h5555, 32'h55555555),
                      0, '0});
      rows.push_back('{mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA, 160000), 0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         send_frame(r.fr, r.has_view, r.view);
      end
      drain();

      // Extreme registers saturate the goals; a write to an unused index is ignored.
      write_csr(ccs_pkg::REG_DISTANCE, 23'h7FFFFF);
      write_csr(ccs_pkg::REG_HEIGHT, 23'h7FFFFF);
      write_csr(ccs_pkg::REG_LOOK, 23'h7FFFFF);
      write_csr(RegUnused, 23'h123456);
      send_frame(mk(32'h7FFFF000, 32'h7FFFF000, 32'h80001000, 16'h0000, 32'h80000000), 0, '0);
      send_frame(mk(32'h80001000, 32'h80001000, 32'h7FFFF000, 16'h8000, 32'h80000000), 0, '0);
      drain();

      // Long receiver hold-off while frames keep coming, so the block stalls its input.
      hold_off = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_frame(random_frame(), 0, '0);
      join
      drain();

      for (int p = 0; p < 4; p++) begin
         write_csr(ccs_pkg::REG_DISTANCE, setting[p][0]);
         write_csr(ccs_pkg::REG_HEIGHT, setting[p][1]);
         write_csr(ccs_pkg::REG_LOOK, setting[p][2]);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int i = 0; i < RandomFrames / 4; i++) send_frame(random_frame(), 0, '0);
         drain();
      end

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
